// ===== hdl/tbp_pkg.sv =====
// Shared types and constants for the tournament branch predictor.
`timescale 1ns / 1ps
package tbp_pkg;

	localparam logic [1:0] CMD_BRANCH   = 2'd0;
	localparam logic [1:0] CMD_CALL     = 2'd1;
	localparam logic [1:0] CMD_RETURN   = 2'd2;
	localparam logic [1:0] CMD_INDIRECT = 2'd3;

	localparam logic CFG_LOCAL_EN  = 1'b0;
	localparam logic CFG_GLOBAL_EN = 1'b1;

	// Chooser counters are sized for the largest supported saturation value.
	localparam int CHOOSER_W = 4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] branch_pc;
		logic        was_taken;
		logic [31:0] target;
	} tbp_in_t;

	typedef struct packed {
		logic        mispredicted;
		logic        predicted_taken;
		logic [31:0] predicted_target;
		logic [31:0] penalty_count;
	} tbp_out_t;

endpackage

// ===== hdl/tbp_fifo.sv =====
// Two-entry queue that decouples the front part from the back part.
`timescale 1ns / 1ps
module tbp_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output logic [WIDTH-1:0] head
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== hdl/tbp_front.sv =====
// Front part: accepts transactions, runs the return stack and global history, forms indices.
`timescale 1ns / 1ps
module tbp_front import tbp_pkg::*; #(
	parameter int HISTORY_ENTRIES      = 1024,
	parameter int BTB_ENTRIES          = 512,
	parameter int RETURN_STACK_ENTRIES = 16,
	parameter int ENTRY_W              = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  tbp_in_t            in_data,
	input  logic               busy,
	input  logic               q_full,
	output logic               push,
	output logic [ENTRY_W-1:0] push_data
);

	localparam int HW = $clog2(HISTORY_ENTRIES);
	localparam int BW = $clog2(BTB_ENTRIES);
	localparam int SW = $clog2(RETURN_STACK_ENTRIES);
	localparam logic [HW-1:0] HMASK = HW'(HISTORY_ENTRIES - 1);
	localparam logic [BW-1:0] BMASK = BW'(BTB_ENTRIES - 1);
	localparam logic [SW-1:0] SMASK = SW'(RETURN_STACK_ENTRIES - 1);

	typedef struct packed {
		logic [1:0]    cmd;
		logic          taken;
		logic [31:0]   target;
		logic [HW-1:0] hs;
		logic [HW-1:0] hd;
		logic [BW-1:0] bidx;
		logic [31:0]   ret_target;
		logic          backward;
	} entry_t;

	logic [31:0]   stack_q [RETURN_STACK_ENTRIES];
	logic [SW-1:0] sp_q;
	logic [HW-1:0] ghist_q;
	logic [SW-1:0] sp_dn;
	logic [SW-1:0] sp_up;
	logic          is_br;
	entry_t        e;

	assign in_stall = busy || q_full;
	assign push     = in_valid && !in_stall;
	assign sp_dn    = (sp_q - SW'(1)) & SMASK;
	assign sp_up    = (sp_q + SW'(1)) & SMASK;
	assign is_br    = (in_data.cmd == CMD_BRANCH) || (in_data.cmd == CMD_CALL);

	always_comb begin
		e.cmd        = in_data.cmd;
		e.taken      = in_data.was_taken;
		e.target     = in_data.target;
		e.hs         = in_data.branch_pc[HW-1:0] & HMASK;
		e.hd         = (e.hs ^ ghist_q) & HMASK;
		e.bidx       = in_data.branch_pc[BW-1:0] & BMASK;
		e.ret_target = stack_q[sp_dn];
		e.backward   = (in_data.target <= in_data.branch_pc);
	end

	assign push_data = ENTRY_W'(e);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= '0;
			ghist_q <= '0;
			for (int i = 0; i < RETURN_STACK_ENTRIES; i++) stack_q[i] <= '0;
		end else if (push) begin
			case (in_data.cmd)
				CMD_RETURN, CMD_INDIRECT: sp_q <= sp_dn;
				CMD_CALL: begin
					if (in_data.was_taken) begin
						stack_q[sp_q] <= in_data.branch_pc + 32'd1;
						sp_q          <= sp_up;
					end
				end
				default: ;
			endcase
			if (is_br) ghist_q <= {ghist_q[HW-2:0], in_data.was_taken} & HMASK;
		end
	end

endmodule

// ===== hdl/tbp_back.sv =====
// Back part: direction tables, target buffer, chooser training and the result register.
`timescale 1ns / 1ps
module tbp_back import tbp_pkg::*; #(
	parameter int HISTORY_ENTRIES = 1024,
	parameter int BTB_ENTRIES     = 512,
	parameter int CHOOSER_MAX     = 3,
	parameter int ENTRY_W         = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               local_en,
	input  logic               global_en,
	input  logic               q_not_empty,
	input  logic [ENTRY_W-1:0] q_head,
	output logic               pop,
	output logic               busy,
	output logic               out_valid,
	input  logic               out_stall,
	output tbp_out_t           out_data
);

	localparam int HW   = $clog2(HISTORY_ENTRIES);
	localparam int BW   = $clog2(BTB_ENTRIES);
	localparam int MAXN = (HISTORY_ENTRIES > BTB_ENTRIES) ? HISTORY_ENTRIES : BTB_ENTRIES;
	localparam int CW   = $clog2(MAXN);
	localparam logic [CHOOSER_W-1:0] CH_MAX  = CHOOSER_W'(CHOOSER_MAX);
	localparam logic [CHOOSER_W-1:0] CH_HALF = CHOOSER_W'(CHOOSER_MAX / 2);

	typedef struct packed {
		logic [1:0]    cmd;
		logic          taken;
		logic [31:0]   target;
		logic [HW-1:0] hs;
		logic [HW-1:0] hd;
		logic [BW-1:0] bidx;
		logic [31:0]   ret_target;
		logic          backward;
	} entry_t;

	logic [1:0]           lh_mem  [HISTORY_ENTRIES];
	logic [CHOOSER_W-1:0] ch_mem  [HISTORY_ENTRIES];
	logic                 po_mem  [HISTORY_ENTRIES];
	logic [31:0]          btb_mem [BTB_ENTRIES];

	logic                 clearing_q;
	logic [CW-1:0]        clr_cnt_q;
	logic                 clr_h;
	logic                 clr_b;

	logic                 b1_v_q;
	entry_t               b1_s1;
	logic [1:0]           lh_s1;
	logic [CHOOSER_W-1:0] ch_s1;
	logic                 po_s1;
	logic [31:0]          btb_s1;

	logic                 out_v_q;
	tbp_out_t             out_q;
	logic [31:0]          pen_q;

	entry_t               e;
	logic                 adv;
	logic                 b1_br;
	logic                 b1_ind;
	logic                 loc, glo, use_glo, loc_ok, glo_ok;
	logic                 pred_taken;
	logic [31:0]          pred_target;
	logic                 miss;
	logic [1:0]           lh_new;
	logic [CHOOSER_W-1:0] ch_new;
	logic [31:0]          pen_next;

	assign e      = entry_t'(q_head);
	assign busy   = clearing_q;
	assign adv    = b1_v_q && (!out_v_q || !out_stall);
	assign pop    = q_not_empty && !clearing_q && (!b1_v_q || adv);
	assign b1_br  = (b1_s1.cmd == CMD_BRANCH) || (b1_s1.cmd == CMD_CALL);
	assign b1_ind = (b1_s1.cmd == CMD_INDIRECT);
	assign clr_h  = ({1'b0, clr_cnt_q} < (CW + 1)'(HISTORY_ENTRIES));
	assign clr_b  = ({1'b0, clr_cnt_q} < (CW + 1)'(BTB_ENTRIES));

	always_comb begin
		loc         = lh_s1[1];
		glo         = po_s1;
		use_glo     = ch_s1 > CH_HALF;
		loc_ok      = (loc == b1_s1.taken);
		glo_ok      = (glo == b1_s1.taken);
		lh_new      = {lh_s1[0], b1_s1.taken};
		ch_new      = ch_s1;
		pred_taken  = 1'b1;
		pred_target = '0;
		miss        = 1'b0;
		if (local_en && global_en && loc_ok && !glo_ok && ch_s1 != '0)
			ch_new = ch_s1 - CHOOSER_W'(1);
		else if (glo_ok && !loc_ok && ch_s1 < CH_MAX)
			ch_new = ch_s1 + CHOOSER_W'(1);
		case (b1_s1.cmd)
			CMD_INDIRECT: begin
				pred_target = btb_s1;
				miss        = (btb_s1 != b1_s1.target);
			end
			CMD_RETURN: begin
				pred_target = b1_s1.ret_target;
				miss        = (b1_s1.ret_target != b1_s1.target);
			end
			default: begin
				if (!local_en && !global_en) pred_taken = b1_s1.backward;
				else if (local_en && global_en) pred_taken = use_glo ? glo : loc;
				else if (local_en) pred_taken = loc;
				else pred_taken = glo;
				miss = (pred_taken != b1_s1.taken);
			end
		endcase
		pen_next = (miss && pen_q != '1) ? pen_q + 32'd1 : pen_q;
	end

	// Table reads happen as a transaction leaves the queue; the transaction in
	// the compute stage forwards its update when it targets the same entry.
	always_ff @(posedge clk) begin
		if (pop) begin
			b1_s1  <= e;
			lh_s1  <= (adv && b1_br && b1_s1.hs == e.hs) ? lh_new : lh_mem[e.hs];
			ch_s1  <= (adv && b1_br && b1_s1.hs == e.hs) ? ch_new : ch_mem[e.hs];
			po_s1  <= (adv && b1_br && b1_s1.hd == e.hd) ? b1_s1.taken : po_mem[e.hd];
			btb_s1 <= (adv && b1_ind && b1_s1.bidx == e.bidx) ? b1_s1.target
				: btb_mem[e.bidx];
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (clr_h) begin
				lh_mem[clr_cnt_q[HW-1:0]] <= '0;
				ch_mem[clr_cnt_q[HW-1:0]] <= '0;
				po_mem[clr_cnt_q[HW-1:0]] <= 1'b0;
			end
			if (clr_b) btb_mem[clr_cnt_q[BW-1:0]] <= '0;
		end else if (adv) begin
			if (b1_br) begin
				lh_mem[b1_s1.hs] <= lh_new;
				ch_mem[b1_s1.hs] <= ch_new;
				po_mem[b1_s1.hd] <= b1_s1.taken;
			end
			if (b1_ind) btb_mem[b1_s1.bidx] <= b1_s1.target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
			b1_v_q     <= 1'b0;
			out_v_q    <= 1'b0;
			pen_q      <= '0;
		end else begin
			if (clearing_q) begin
				clr_cnt_q <= clr_cnt_q + CW'(1);
				if (clr_cnt_q == CW'(MAXN - 1)) clearing_q <= 1'b0;
			end
			if (pop) b1_v_q <= 1'b1;
			else if (adv) b1_v_q <= 1'b0;
			if (adv) begin
				out_v_q <= 1'b1;
				pen_q   <= pen_next;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.mispredicted     <= miss;
			out_q.predicted_taken  <= pred_taken;
			out_q.predicted_target <= pred_target;
			out_q.penalty_count    <= pen_next;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

// ===== hdl/tournament_branch_predictor_core.sv =====
// Tournament branch predictor with return stack and target buffer: top level.
//
// One resolved control transfer enters on the input channel (in_valid/in_stall,
// in_data); one result leaves on the output channel (out_valid/out_stall,
// out_data) for every transaction, in order. A transaction is moved at a clock
// edge where valid is high and stall is low.
// When nothing stalls, the front part forms table indices and updates the return
// stack and global history as it accepts, writing the two-entry queue at the
// accepting edge; the back part then reads the tables into its stage register
// as the transaction leaves the queue and writes the result register from
// that stage. Throughput is one transaction per cycle when nothing stalls, set by
// the single read and write port of each table.
// After reset a clearing pass zeroes every table entry, one entry per cycle; in_stall
// is high during it. Configuration (cfg_we, cfg_index, cfg_data) takes effect when
// a transaction reaches the back part, so the user must write it only while no
// transaction is in flight; the block does not enforce this.
// When the receiver stalls, the result register holds and the queue fills;
// in_stall rises once the queue is full.
`timescale 1ns / 1ps
module tournament_branch_predictor_core import tbp_pkg::*; #(
	parameter int HISTORY_ENTRIES      = 1024,
	parameter int BTB_ENTRIES          = 512,
	parameter int RETURN_STACK_ENTRIES = 16,
	parameter int CHOOSER_MAX          = 3
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_index,
	input  logic     cfg_data,
	input  logic     in_valid,
	output logic     in_stall,
	input  tbp_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output tbp_out_t out_data
);

	localparam int HW      = $clog2(HISTORY_ENTRIES);
	localparam int BW      = $clog2(BTB_ENTRIES);
	localparam int ENTRY_W = 2 + 1 + 32 + HW + HW + BW + 32 + 1;

	logic               local_en_q;
	logic               global_en_q;
	logic               busy;
	logic               q_full;
	logic               q_not_empty;
	logic               push;
	logic               pop;
	logic [ENTRY_W-1:0] push_data;
	logic [ENTRY_W-1:0] q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_en_q  <= 1'b1;
			global_en_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOCAL_EN:  local_en_q  <= cfg_data;
				CFG_GLOBAL_EN: global_en_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tbp_front #(
		.HISTORY_ENTRIES(HISTORY_ENTRIES),
		.BTB_ENTRIES(BTB_ENTRIES),
		.RETURN_STACK_ENTRIES(RETURN_STACK_ENTRIES),
		.ENTRY_W(ENTRY_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.busy(busy),
		.q_full(q_full),
		.push(push),
		.push_data(push_data)
	);

	tbp_fifo #(
		.WIDTH(ENTRY_W)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.full(q_full),
		.not_empty(q_not_empty),
		.head(q_head)
	);

	tbp_back #(
		.HISTORY_ENTRIES(HISTORY_ENTRIES),
		.BTB_ENTRIES(BTB_ENTRIES),
		.CHOOSER_MAX(CHOOSER_MAX),
		.ENTRY_W(ENTRY_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.local_en(local_en_q),
		.global_en(global_en_q),
		.q_not_empty(q_not_empty),
		.q_head(q_head),
		.pop(pop),
		.busy(busy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

endmodule

// ===== hdl/tbp_checker.sv =====
// Port-level checks for the branch predictor and their binding to the top level.
`timescale 1ns / 1ps
module tbp_checker import tbp_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     in_stall,
	input logic     out_valid,
	input logic     out_stall,
	input tbp_out_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result was dropped or changed");

	a_clear_stall: assert property (@(posedge clk)
		arst_n && !$past(arst_n) |-> in_stall)
		else $error("input accepted before the tables were cleared");

	a_miss_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.mispredicted |-> out_data.penalty_count != 32'd0)
		else $error("misprediction without a nonzero penalty count");

	a_dir_no_target: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.predicted_taken |-> out_data.predicted_target == 32'd0)
		else $error("not-taken prediction carries a target");

endmodule

bind tournament_branch_predictor_core tbp_checker u_tbp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);
